[rtl/mmac_pkg.sv]
// Shared types and constants for the modular multiply-add MAC accumulator.
// Holds word widths, the sequencer state type and the modular unit operand bundle.
// No dependencies.
package mmac_pkg;

	// external field width and internal arithmetic width
	localparam int FIELD_W   = 64;
	localparam int WORD_BITS = 64;
	localparam int CNT_W     = $clog2(WORD_BITS);

	localparam logic [CNT_W-1:0]   CNT_LAST      = CNT_W'(WORD_BITS - 1);
	localparam logic [FIELD_W-1:0] MODULUS_RESET = 64'h1FFF_FFFF_FFFF_FFFF;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_RED_G,
		ST_MUL,
		ST_ADD_B,
		ST_ADD_G,
		ST_ZERO
	} mmac_state_t;

	// one step of the modular unit: (dbl ? 2*acc : acc) + addend, reduced mod q
	typedef struct packed {
		logic                 dbl;
		logic [WORD_BITS-1:0] acc;
		logic [WORD_BITS-1:0] addend;
	} mmac_op_t;

endpackage

[rtl/mmac_item_if.sv]
// Input channel: one message block with its key pair and first-block flag.
// Depends on mmac_pkg.
interface mmac_item_if
	import mmac_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] coef_a;
	logic [FIELD_W-1:0] coef_b;
	logic [FIELD_W-1:0] message_block;
	logic               first_block;

	modport source (output valid, coef_a, coef_b, message_block, first_block, input ready);
	modport sink   (input valid, coef_a, coef_b, message_block, first_block, output ready);
endinterface

[rtl/mmac_result_if.sv]
// Output channel: per-block tag and running aggregate tag.
// Depends on mmac_pkg.
interface mmac_result_if
	import mmac_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] block_tag;
	logic [FIELD_W-1:0] aggregate_tag;

	modport source (output valid, block_tag, aggregate_tag, input ready);
	modport sink   (input valid, block_tag, aggregate_tag, output ready);
endinterface

[rtl/mmac_modunit.sv]
// Shared modular step unit: optional doubling, one add, reduction by q or 2q.
// Requires acc < q and addend < q (or addend of one); the sum then stays below 3q.
// Depends on mmac_pkg.
module mmac_modunit
	import mmac_pkg::*;
(
	input  mmac_op_t             op,
	input  logic [WORD_BITS-1:0] q,
	output logic [WORD_BITS-1:0] res
);

	logic [WORD_BITS+1:0] sum;
	logic [WORD_BITS+1:0] q1;
	logic [WORD_BITS+1:0] q2;
	logic [WORD_BITS+1:0] d1;
	logic [WORD_BITS+1:0] d2;

	// widened sum and the two candidate corrections
	always_comb begin
		q1  = {2'b00, q};
		q2  = {1'b0, q, 1'b0};
		sum = (op.dbl ? {1'b0, op.acc, 1'b0} : {2'b00, op.acc}) + {2'b00, op.addend};
		d1  = sum - q1;
		d2  = sum - q2;
	end

	// pick the in-range candidate
	always_comb begin
		if (sum >= q2) begin
			res = d2[WORD_BITS-1:0];
		end else if (sum >= q1) begin
			res = d1[WORD_BITS-1:0];
		end else begin
			res = sum[WORD_BITS-1:0];
		end
	end

endmodule

[rtl/modular_mul_add_mac_accumulator.sv]
// Modular multiply-add MAC accumulator: tag = (a*m + b) mod q, aggregate += tag mod q.
// After the input transfer: reduce a, then b, then the stored aggregate when it needs reduction
// after a modulus write, then multiply, add b and add into the aggregate; q of zero gives zeros.
// One item at a time: a new item is taken only in idle; the single modular step unit works one bit a cycle.
// Reset: modulus to 2^61-1, aggregate to zero, sequencer idle, no result pending.
// Depends on mmac_pkg, mmac_item_if, mmac_result_if, mmac_modunit.
module modular_mul_add_mac_accumulator
	import mmac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata,
	mmac_item_if.sink          item,
	mmac_result_if.source      result
);

	mmac_state_t state_q, state_d;

	logic [FIELD_W-1:0]   modulus_q;
	logic [WORD_BITS-1:0] q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] agg_q;
	logic                 agg_ok_q;
	logic                 first_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] tag_out_q;
	logic [WORD_BITS-1:0] agg_out_q;
	logic                 out_valid_q;

	mmac_op_t             op;
	logic [WORD_BITS-1:0] res;
	logic                 last;
	logic                 out_free;
	logic                 item_xfer;

	assign q         = modulus_q[WORD_BITS-1:0];
	assign last      = (cnt_q == '0);
	assign out_free  = !out_valid_q || result.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign item_xfer = item.valid && item.ready;

	assign result.valid         = out_valid_q;
	assign result.block_tag     = FIELD_W'(tag_out_q);
	assign result.aggregate_tag = FIELD_W'(agg_out_q);

	mmac_modunit u_modunit (
		.op  (op),
		.q   (q),
		.res (res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_xfer) begin
					state_d = (q == '0) ? ST_ZERO : ST_RED_A;
				end
			end
			ST_RED_A: begin
				if (last) state_d = ST_RED_B;
			end
			ST_RED_B: begin
				if (last) state_d = (first_q || agg_ok_q) ? ST_MUL : ST_RED_G;
			end
			ST_RED_G: begin
				if (last) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (last) state_d = ST_ADD_B;
			end
			ST_ADD_B: state_d = ST_ADD_G;
			ST_ADD_G, ST_ZERO: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand select for the shared unit
	always_comb begin
		op = '0;
		case (state_q)
			ST_RED_A: begin
				op.dbl    = 1'b1;
				op.acc    = acc_q;
				op.addend = WORD_BITS'(a_q[WORD_BITS-1]);
			end
			ST_RED_B: begin
				op.dbl    = 1'b1;
				op.acc    = acc_q;
				op.addend = WORD_BITS'(b_q[WORD_BITS-1]);
			end
			ST_RED_G: begin
				op.dbl    = 1'b1;
				op.acc    = acc_q;
				op.addend = WORD_BITS'(agg_q[WORD_BITS-1]);
			end
			ST_MUL: begin
				op.dbl    = 1'b1;
				op.acc    = acc_q;
				op.addend = m_q[WORD_BITS-1] ? a_q : '0;
			end
			ST_ADD_B: begin
				op.acc    = acc_q;
				op.addend = b_q;
			end
			ST_ADD_G: begin
				op.acc    = first_q ? '0 : agg_q;
				op.addend = acc_q;
			end
			default: op = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and aggregate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			agg_q     <= '0;
			agg_ok_q  <= 1'b1;
			acc_q     <= '0;
			cnt_q     <= CNT_LAST;
			a_q       <= '0;
			b_q       <= '0;
			m_q       <= '0;
			first_q   <= 1'b0;
			tag_out_q <= '0;
			agg_out_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						a_q     <= item.coef_a[WORD_BITS-1:0];
						b_q     <= item.coef_b[WORD_BITS-1:0];
						m_q     <= item.message_block[WORD_BITS-1:0];
						first_q <= item.first_block;
						acc_q   <= '0;
						cnt_q   <= CNT_LAST;
					end
				end
				// operand reductions: Horner over the operand bits, result written back
				ST_RED_A: begin
					a_q   <= last ? res : (a_q << 1);
					acc_q <= last ? '0 : res;
					cnt_q <= last ? CNT_LAST : cnt_q - 1'b1;
				end
				ST_RED_B: begin
					b_q   <= last ? res : (b_q << 1);
					acc_q <= last ? '0 : res;
					cnt_q <= last ? CNT_LAST : cnt_q - 1'b1;
				end
				ST_RED_G: begin
					agg_q <= last ? res : (agg_q << 1);
					acc_q <= last ? '0 : res;
					cnt_q <= last ? CNT_LAST : cnt_q - 1'b1;
					if (last) agg_ok_q <= 1'b1;
				end
				// double-and-add over the message bits
				ST_MUL: begin
					m_q   <= m_q << 1;
					acc_q <= res;
					cnt_q <= last ? CNT_LAST : cnt_q - 1'b1;
				end
				ST_ADD_B: begin
					acc_q <= res;
				end
				ST_ADD_G: begin
					if (out_free) begin
						tag_out_q <= acc_q;
						agg_out_q <= res;
						agg_q     <= res;
						agg_ok_q  <= 1'b1;
					end
				end
				ST_ZERO: begin
					if (out_free) begin
						tag_out_q <= '0;
						agg_out_q <= '0;
						agg_q     <= '0;
						agg_ok_q  <= 1'b1;
					end
				end
				default: ;
			endcase
			// modulus write; the stored aggregate must be reduced again
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
				agg_ok_q  <= 1'b0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_ADD_G || state_q == ST_ZERO) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// checks
	a_res_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && q != '0 |->
			agg_out_q < q && tag_out_q < q)
		else $error("result not reduced below modulus");

	a_acc_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE && state_q != ST_ZERO && q != '0 |-> acc_q < q)
		else $error("unit accumulator out of range");

	a_new_result_agg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_G || state_q == ST_ZERO) && out_free |=>
			result.valid && agg_q == agg_out_q)
		else $error("aggregate state and delivered aggregate differ");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second item taken while busy");

endmodule
